@@ design/psf_pkg.sv @@
// shared types, constants and helpers for the payload multi-string filter
// no dependencies
`timescale 1ns / 1ps

package psf_pkg;

  localparam int unsigned NumPatterns   = 4;
  localparam int unsigned MaxPatternLen = 8;
  localparam int unsigned PatBits       = 8 * MaxPatternLen;
  localparam int unsigned HistBits      = 8 * (MaxPatternLen - 1);
  localparam int unsigned LenW          = 4;
  localparam int unsigned SeenW         = $clog2(MaxPatternLen);
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPattern0  = 3'd0,
    CfgPattern1  = 3'd1,
    CfgPattern2  = 3'd2,
    CfgPattern3  = 3'd3,
    CfgLengths   = 3'd4,
    CfgKindMask  = 3'd5
  } cfg_idx_e;

  // decoded configuration seen by the matcher
  typedef struct packed {
    logic [NumPatterns-1:0][PatBits-1:0] pat;
    logic [NumPatterns-1:0][LenW-1:0]    len;
    logic [NumPatterns-1:0]              absent;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic                   verdict;
    logic [NumPatterns-1:0] found_mask;
  } res_t;

  // length nibble saturated at the longest pattern
  function automatic logic [LenW-1:0] sat_len(input logic [LenW-1:0] raw);
    logic [LenW-1:0] lim;
    lim = LenW'(MaxPatternLen);
    return (raw > lim) ? lim : raw;
  endfunction

endpackage

@@ design/psf_cfg_regs.sv @@
// configuration registers of the payload filter: pattern bytes, lengths, kinds
// depends on psf_pkg
`timescale 1ns / 1ps

module psf_cfg_regs
  import psf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  logic [NumPatterns-1:0][PatBits-1:0] pat_q;
  logic [15:0]                         lengths_q;
  logic [3:0]                          kind_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      lengths_q <= '0;
      kind_q    <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CfgPattern0: pat_q[0]  <= wr_data_i[PatBits-1:0];
        CfgPattern1: pat_q[1]  <= wr_data_i[PatBits-1:0];
        CfgPattern2: pat_q[2]  <= wr_data_i[PatBits-1:0];
        CfgPattern3: pat_q[3]  <= wr_data_i[PatBits-1:0];
        CfgLengths:  lengths_q <= wr_data_i[15:0];
        CfgKindMask: kind_q    <= wr_data_i[3:0];
        default: ;
      endcase
    end
  end

  // decoded view with saturated lengths
  always_comb begin
    for (int k = 0; k < NumPatterns; k++) begin
      cfg_o.pat[k]    = pat_q[k];
      cfg_o.len[k]    = sat_len(lengths_q[LenW*k +: LenW]);
      cfg_o.absent[k] = kind_q[k];
    end
  end

endmodule

@@ design/psf_matcher.sv @@
// per-packet byte history, pattern compare against the window and verdict
// depends on psf_pkg
`timescale 1ns / 1ps

module psf_matcher
  import psf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       empty_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [HistBits-1:0]    recent_q, recent_d;
  logic [SeenW-1:0]       seen_q, seen_d;
  logic [NumPatterns-1:0] flags_q, flags_d;
  logic [PatBits-1:0]     win;
  logic [LenW-1:0]        avail;
  logic [NumPatterns-1:0] hit;
  logic                   match;
  logic [SeenW-1:0]       age;
  logic                   verdict;

  // window with the newest byte in the low bits
  assign win   = {recent_q, byte_i};
  assign avail = LenW'(seen_q) + LenW'(1);

  // each pattern ending at the newest byte
  always_comb begin
    hit   = '0;
    match = 1'b0;
    age   = '0;
    for (int k = 0; k < NumPatterns; k++) begin
      match = (cfg_i.len[k] != '0) && (avail >= cfg_i.len[k]);
      for (int i = 0; i < MaxPatternLen; i++) begin
        if (LenW'(i) < cfg_i.len[k]) begin
          age = SeenW'(cfg_i.len[k] - LenW'(i) - LenW'(1));
          if (cfg_i.pat[k][8*i +: 8] != win[{age, 3'b000} +: 8]) begin
            match = 1'b0;
          end
        end
      end
      hit[k] = match;
    end
  end

  assign flags_d = flags_q | hit;

  // verdict over the used patterns
  always_comb begin
    verdict = 1'b1;
    for (int k = 0; k < NumPatterns; k++) begin
      if (cfg_i.len[k] != '0) begin
        if (cfg_i.absent[k] ? flags_d[k] : !flags_d[k]) begin
          verdict = 1'b0;
        end
      end
    end
  end

  assign res_o.verdict    = empty_i ? 1'b0 : verdict;
  assign res_o.found_mask = empty_i ? '0 : flags_d;

  // history advance, saturating byte count
  assign recent_d = win[HistBits-1:0];
  assign seen_d   = (seen_q == SeenW'(MaxPatternLen - 1)) ? seen_q : seen_q + SeenW'(1);

  // per-packet state, cleared at packet end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      seen_q   <= '0;
      flags_q  <= '0;
    end else if (step_i) begin
      if (empty_i || last_i) begin
        recent_q <= '0;
        seen_q   <= '0;
        flags_q  <= '0;
      end else begin
        recent_q <= recent_d;
        seen_q   <= seen_d;
        flags_q  <= flags_d;
      end
    end
  end

endmodule

@@ design/payload_multi_string_filter.sv @@
// payload multi-string filter: input register, window match, result register
// last byte of a packet: input register, then result register when that is free
// throughput: one byte per cycle; the only stall is a held result at packet end
// reset: asynchronous active low; patterns, lengths, kinds and packet state clear
// depends on psf_pkg, psf_cfg_regs, psf_matcher
`timescale 1ns / 1ps

module payload_multi_string_filter
  import psf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             payload_byte_i,
  input  logic                   last_byte_i,
  input  logic                   no_payload_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   verdict_o,
  output logic [NumPatterns-1:0] found_mask_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_empty_q;
  logic       s1_has_res;
  logic       s1_go;
  logic       s1_emit;
  logic       in_fire;
  logic       out_free;
  logic       out_valid_q, out_valid_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  psf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake between input stage and result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_has_res = s1_last_q || s1_empty_q;
  assign s1_go      = s1_valid_q && (!s1_has_res || out_free);
  assign s1_emit    = s1_go && s1_has_res;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= payload_byte_i;
      s1_last_q  <= last_byte_i;
      s1_empty_q <= no_payload_i;
    end
  end

  psf_matcher u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_go),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .empty_i (s1_empty_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // result register
  assign out_valid_d = s1_emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = res_q.verdict;
  assign found_mask_o = res_q.found_mask;

endmodule
